// File: hdl/bpng_pkg.sv
// ----------------------------------------------------------------------------
// bpng_pkg
// Types, register codes, fixed-point constants and elaboration-time helpers
// for the band PCEN noise gate.
// ----------------------------------------------------------------------------
`default_nettype none

package bpng_pkg;

  typedef enum logic [2:0] {
    REG_ENERGY_FLOOR,
    REG_NOISE_FALL,
    REG_NOISE_RISE,
    REG_GATE_OPEN,
    REG_GATE_CLOSE,
    REG_SMOOTH,
    REG_LEVEL_GAIN,
    REG_ONSET_GAIN
  } reg_idx_e;

  localparam int unsigned NUM_REGS = 8;
  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'd105, 16'd5243, 16'd131, 16'd5939, 16'd4833, 16'd6554, 16'd4608, 16'd1536
  };

  localparam logic [31:0]        EPS_Q20   = 32'd105;
  localparam logic signed [39:0] EXP_Q16   = 40'sd53740;  // 0.82
  localparam logic [40:0]        BIAS_Q16  = 41'd183501;  // 2.8
  localparam logic [15:0]        LEVEL_MAX = 16'd64000;
  localparam logic [39:0]        R_MAX     = 40'hFF_FFFF_FFFF;
  localparam logic [23:0]        PCEN_MAX  = 24'hFF_FFFF;

  // sideband that travels with every word
  typedef struct packed {
    logic       vld;
    logic       ok;     // band within range
    logic [4:0] band;
    logic       gate;
    logic       ezero;  // gated energy is zero
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-n) in Q1.30, built by repeated floor square roots
  function automatic logic [31:0] exp_root(input int n);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= n) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

  localparam logic [63:0] SQ0_FULL = isqrt64(64'(BIAS_Q16) << 16);
  localparam logic [29:0] SQ0      = SQ0_FULL[29:0];

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hdl/band_pcen_noise_gate_core.sv
// ----------------------------------------------------------------------------
// band_pcen_noise_gate_core
// Per-band noise floor, hysteretic gate, PCEN compression and onset emphasis.
// ----------------------------------------------------------------------------
// One band word is taken every cycle while in_stall_o is low, and one result
// leaves for every word, in order. The pipeline runs through the 16-stage log2
// lanes, the 16-stage exp2 multiplier chain and the 15-stage square root; the
// per-band stores are each read and written within a single stage, so words of
// the same band may follow each other back to back. All per-band stores
// are flip-flops cleared at once by reset. A two-entry output (register plus
// skid) decouples the pipeline from the output stall.
`default_nettype none

module band_pcen_noise_gate_core #(
  parameter int unsigned BANDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [4:0]  band_i,
  input  wire logic [31:0] energy_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       band_out_o,
  output logic [15:0]      level_o,
  output logic             gate_open_o
);
  import bpng_pkg::*;

  localparam int unsigned DEPTH = (BANDS < 32) ? BANDS : 32;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] cfg_q [NUM_REGS];
  logic        en;
  logic        skid_vld_q;
  logic        out_vld_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---------------------------------------------------------------- stage A
  side_t       a_side_q;
  logic [31:0] a_e_q;
  logic [31:0] e_floor;
  logic        a_ok;

  always_comb begin
    e_floor = (energy_i < 32'(cfg_q[REG_ENERGY_FLOOR])) ?
              32'(cfg_q[REG_ENERGY_FLOOR]) : energy_i;
    a_ok    = 32'(band_i) < BANDS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
    end else if (en) begin
      a_side_q <= '{vld: in_valid_i, ok: a_ok, band: band_i, gate: 1'b0, ezero: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) a_e_q <= e_floor;
  end

  // ---------------------------------------------------------------- stage B: noise
  logic [31:0] nf_q [DEPTH];
  logic [IW-1:0] a_idx;
  logic [31:0] nf_old, n_new;
  logic [15:0] nw;
  logic [16:0] nwc;
  logic [49:0] nacc;
  side_t       b_side_q;
  logic [31:0] b_e_q, b_n_q;

  always_comb begin
    a_idx  = a_side_q.band[IW-1:0];
    nf_old = nf_q[a_idx];
    nw     = (a_e_q < nf_old) ? cfg_q[REG_NOISE_FALL] : cfg_q[REG_NOISE_RISE];
    nwc    = 17'h10000 - {1'b0, nw};
    nacc   = 50'(nf_old) * 50'(nwc) + 50'(a_e_q) * 50'(nw);
    n_new  = (nf_old == '0) ? a_e_q : nacc[47:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) nf_q[i] <= '0;
      b_side_q <= '0;
    end else if (en) begin
      if (a_side_q.vld && a_side_q.ok) nf_q[a_idx] <= n_new;
      b_side_q <= a_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_e_q <= a_e_q;
      b_n_q <= n_new;
    end
  end

  // ---------------------------------------------------------------- stage C: gate
  logic          gt_q [DEPTH];
  logic [IW-1:0] b_idx;
  logic [47:0]   gex, gpo, gpc;
  logic          g_old, g_new;
  side_t         c_side_q;
  logic [31:0]   c_ge_q;

  always_comb begin
    b_idx = b_side_q.band[IW-1:0];
    gex   = {4'b0, b_e_q, 12'b0};
    gpo   = 48'(b_n_q) * 48'(cfg_q[REG_GATE_OPEN]);
    gpc   = 48'(b_n_q) * 48'(cfg_q[REG_GATE_CLOSE]);
    g_old = gt_q[b_idx];
    g_new = g_old ? !(gex < gpc) : (gex > gpo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) gt_q[i] <= 1'b0;
      c_side_q <= '0;
    end else if (en) begin
      if (b_side_q.vld && b_side_q.ok) gt_q[b_idx] <= g_new;
      c_side_q <= '{vld: b_side_q.vld, ok: b_side_q.ok, band: b_side_q.band,
                    gate: b_side_q.ok && g_new, ezero: b_side_q.ezero};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) c_ge_q <= g_new ? b_e_q : b_n_q;
  end

  // ---------------------------------------------------------------- stage D: smoothing
  logic [31:0]   sm_q [DEPTH];
  logic [IW-1:0] c_idx;
  logic [31:0]   s_old, s_new, s_x;
  logic [16:0]   swc;
  logic [49:0]   sacc;
  logic [32:0]   s_sum;
  side_t         d_side_q;
  logic [31:0]   d_ge_q, d_x_q;

  always_comb begin
    c_idx = c_side_q.band[IW-1:0];
    s_old = sm_q[c_idx];
    swc   = 17'h10000 - {1'b0, cfg_q[REG_SMOOTH]};
    sacc  = 50'(s_old) * 50'(swc) + 50'(c_ge_q) * 50'(cfg_q[REG_SMOOTH]);
    s_new = (s_old == '0) ? c_ge_q : sacc[47:16];
    s_sum = 33'(s_new) + 33'(EPS_Q20);
    s_x   = s_sum[32] ? 32'hFFFF_FFFF : s_sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) sm_q[i] <= '0;
      d_side_q <= '0;
    end else if (en) begin
      if (c_side_q.vld && c_side_q.ok) sm_q[c_idx] <= s_new;
      d_side_q <= '{vld: c_side_q.vld, ok: c_side_q.ok, band: c_side_q.band,
                    gate: c_side_q.gate, ezero: (c_ge_q == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ge_q <= c_ge_q;
      d_x_q  <= s_x;
    end
  end

  // ---------------------------------------------------------------- log2 lanes
  // lane 0: gated energy, lane 1: smoothed energy plus eps
  side_t       lside_q [17];
  logic [31:0] lm_q [17][2];
  logic [15:0] lf_q [17][2];
  logic [5:0]  lip_q [17][2];
  logic [4:0]  np0, np1;

  always_comb begin
    np0 = msb_pos(d_ge_q);
    np1 = msb_pos(d_x_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lside_q[0] <= '0;
    else if (en) lside_q[0] <= d_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lm_q[0][0]  <= d_ge_q << (5'd31 - np0);
      lm_q[0][1]  <= d_x_q << (5'd31 - np1);
      lf_q[0][0]  <= '0;
      lf_q[0][1]  <= '0;
      lip_q[0][0] <= {1'b0, np0} - 6'd20;
      lip_q[0][1] <= {1'b0, np1} - 6'd20;
    end
  end

  for (genvar j = 0; j < 16; j++) begin : g_log
    logic [63:0] sq [2];
    logic [31:0] mn [2];
    logic        fb [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sq[l] = 64'(lm_q[j][l]) * 64'(lm_q[j][l]);
        fb[l] = sq[l][63];
        mn[l] = fb[l] ? sq[l][63:32] : sq[l][62:31];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) lside_q[j+1] <= '0;
      else if (en) lside_q[j+1] <= lside_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          lm_q[j+1][l]  <= mn[l];
          lf_q[j+1][l]  <= {lf_q[j][l][14:0], fb[l]};
          lip_q[j+1][l] <= lip_q[j][l];
        end
      end
    end
  end

  // ---------------------------------------------------------------- exponent
  logic signed [21:0] le, lx;
  logic signed [39:0] lprod;
  logic signed [23:0] tq;
  side_t       xside_q [17];
  logic [30:0] xm_q [17];
  logic [15:0] xf_q [17];
  logic [7:0]  xk_q [17];

  always_comb begin
    le    = {lip_q[16][0], lf_q[16][0]};
    lx    = {lip_q[16][1], lf_q[16][1]};
    lprod = 40'(lx) * EXP_Q16;
    tq    = 24'(le) - lprod[39:16];  // floor divide by 65536
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) xside_q[0] <= '0;
    else if (en) xside_q[0] <= lside_q[16];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xm_q[0] <= 31'h4000_0000;
      xf_q[0] <= tq[15:0];
      xk_q[0] <= tq[23:16];
    end
  end

  for (genvar i = 1; i <= 16; i++) begin : g_exp
    localparam logic [31:0] ROOT = exp_root(i);
    logic [62:0] xp;

    always_comb xp = 63'(xm_q[i-1]) * 63'(ROOT);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) xside_q[i] <= '0;
      else if (en) xside_q[i] <= xside_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        xm_q[i] <= xf_q[i-1][16-i] ? xp[60:30] : xm_q[i-1];
        xf_q[i] <= xf_q[i-1];
        xk_q[i] <= xk_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- ratio and radicand
  logic signed [8:0] rsh;
  logic [8:0]  rns;
  logic [39:0] rr;
  logic [40:0] rb;
  side_t       qside_q [16];
  logic [59:0] qrad_q [16];
  logic [33:0] qrem_q [16];
  logic [29:0] qroot_q [16];

  always_comb begin
    rsh = $signed({xk_q[16][7], xk_q[16]}) - 9'sd14;
    rns = 9'd0 - rsh;
    if (xside_q[16].ezero) rr = '0;
    else if (rsh > 9'sd9) rr = R_MAX;
    else if (!rsh[8]) rr = 40'(xm_q[16]) << rsh[3:0];
    else if (rns >= 9'd31) rr = '0;
    else rr = 40'(xm_q[16]) >> rns[4:0];
    rb = 41'(rr) + BIAS_Q16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qside_q[0] <= '0;
    else if (en) qside_q[0] <= xside_q[16];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qrad_q[0]  <= {3'b0, rb, 16'b0};
      qrem_q[0]  <= '0;
      qroot_q[0] <= '0;
    end
  end

  // two restoring square root steps per stage
  for (genvar k = 0; k < 15; k++) begin : g_sqrt
    logic [59:0] rad;
    logic [33:0] rem, remn, trial;
    logic [29:0] root;

    always_comb begin
      rad  = qrad_q[k];
      rem  = qrem_q[k];
      root = qroot_q[k];
      remn = '0;
      trial = '0;
      for (int s = 0; s < 2; s++) begin
        remn  = {rem[31:0], rad[59:58]};
        trial = {2'b0, root, 2'b01};
        rad   = {rad[57:0], 2'b00};
        if (remn >= trial) begin
          rem  = remn - trial;
          root = {root[28:0], 1'b1};
        end else begin
          rem  = remn;
          root = {root[28:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) qside_q[k+1] <= '0;
      else if (en) qside_q[k+1] <= qside_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        qrad_q[k+1]  <= rad;
        qrem_q[k+1]  <= rem;
        qroot_q[k+1] <= root;
      end
    end
  end

  // ---------------------------------------------------------------- stage P: pcen, onset
  logic [23:0]   pv_q [DEPTH];
  logic [IW-1:0] q_idx;
  logic [29:0]   pd;
  logic [25:0]   pp;
  logic [23:0]   pcen, pprev;
  side_t         p_side_q;
  logic [23:0]   p_pcen_q, p_trans_q;

  always_comb begin
    q_idx = qside_q[15].band[IW-1:0];
    pd    = (qroot_q[15] > SQ0) ? qroot_q[15] - SQ0 : '0;
    pp    = 26'(pd >> 4);
    pcen  = (pp > 26'(PCEN_MAX)) ? PCEN_MAX : pp[23:0];
    pprev = pv_q[q_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) pv_q[i] <= '0;
      p_side_q <= '0;
    end else if (en) begin
      if (qside_q[15].vld && qside_q[15].ok) pv_q[q_idx] <= pcen;
      p_side_q <= qside_q[15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_pcen_q  <= pcen;
      p_trans_q <= (pcen > pprev) ? pcen - pprev : '0;
    end
  end

  // ---------------------------------------------------------------- output and skid
  logic [40:0] lacc;
  logic [28:0] lraw;
  logic [15:0] res_level;
  logic        res_gate;
  logic        out_take;
  logic [4:0]  out_band_q, skid_band_q;
  logic [15:0] out_level_q, skid_level_q;
  logic        out_gate_q, skid_gate_q;

  always_comb begin
    lacc = 41'(p_pcen_q) * 41'(cfg_q[REG_LEVEL_GAIN])
         + 41'(p_trans_q) * 41'(cfg_q[REG_ONSET_GAIN]);
    lraw = lacc[40:12];
    if (!p_side_q.ok) res_level = '0;
    else if (lraw > 29'(LEVEL_MAX)) res_level = LEVEL_MAX;
    else res_level = lraw[15:0];
    res_gate = p_side_q.ok && p_side_q.gate;
    out_take = out_vld_q && !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= p_side_q.vld;
    end else if (p_side_q.vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_band_q  <= skid_band_q;
        out_level_q <= skid_level_q;
        out_gate_q  <= skid_gate_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_band_q  <= p_side_q.band;
      out_level_q <= res_level;
      out_gate_q  <= res_gate;
    end else begin
      skid_band_q  <= p_side_q.band;
      skid_level_q <= res_level;
      skid_gate_q  <= res_gate;
    end
  end

  assign out_valid_o = out_vld_q;
  assign band_out_o  = out_band_q;
  assign level_o     = out_level_q;
  assign gate_open_o = out_gate_q;

  // ---------------------------------------------------------------- checks
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while output is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> !skid_vld_q)
    else $error("skid did not drain");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (32'(band_out_o) >= BANDS)) |-> (level_o == '0 && !gate_open_o))
    else $error("out of range band produced a level");

endmodule

`default_nettype wire

// File: verif/band_pcen_noise_gate_core_tb.sv
// ----------------------------------------------------------------------------
// band_pcen_noise_gate_core_tb
// Self-checking bench: random and directed band words are pushed through the
// core under random input idling and output stall. A bit-exact fixed-point
// predictor computes the expected level and gate for every accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

class gate_scoreboard;
  typedef struct {
    logic [4:0]  band;
    logic [15:0] level;
    logic        gate;
  } band_result_t;

  band_result_t       pending_q[$];
  int                 errors;
  logic [15:0]        regs [8];
  logic [31:0]        noise [32];
  logic [31:0]        smooth [32];
  logic               gate_st [32];
  logic [23:0]        prev_pcen [32];
  longint unsigned    roots [17];

  function new();
    errors = 0;
    roots[0] = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) roots[i] = sqrt_floor(roots[i-1] << 30);
    clear();
  endfunction

  function void clear();
    regs = '{16'd105, 16'd5243, 16'd131, 16'd5939, 16'd4833, 16'd6554, 16'd4608, 16'd1536};
    for (int i = 0; i < 32; i++) begin
      noise[i] = '0; smooth[i] = '0; gate_st[i] = 1'b0; prev_pcen[i] = '0;
    end
  endfunction

  function longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function logic [31:0] smooth_step(logic [31:0] old, logic [31:0] x, logic [15:0] w);
    longint unsigned acc;
    if (old == 0) return x;
    acc = longint'(old) * (65536 - longint'(w)) + longint'(x) * longint'(w);
    return 32'(acc >> 16);
  endfunction

  // Q12.20 -> Q.16
  function longint log2_energy(logic [31:0] v);
    int p;
    longint unsigned m;
    longint fr;
    p = 31;
    fr = 0;
    while (p > 0 && !v[p]) p--;
    m = longint'(v) << (31 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return longint'(p - 20) * 65536 + fr;
  endfunction

  function longint unsigned pow2_q16(longint t);
    longint k, f, sh;
    longint unsigned m, rmax;
    rmax = (64'd1 << 40) - 1;
    m = 64'd1 << 30;
    k = t >>> 16;
    f = t - k * 65536;
    for (int i = 1; i <= 16; i++)
      if ((f >> (16 - i)) & 1) m = (m * roots[i]) >> 30;
    sh = k - 14;
    if (sh > 9) return rmax;
    if (sh >= 0) begin
      m = m << sh;
      return (m > rmax) ? rmax : m;
    end
    if (sh <= -63) return 0;
    return m >> (-sh);
  endfunction

  function void note_word(logic [4:0] b, logic [31:0] energy);
    band_result_t res;
    logic [31:0] e, n, s;
    longint unsigned r, x, sq, sq0, p, trans, lvl;
    longint lx, t;
    logic [23:0] pcen;
    e = energy;
    if (e < regs[bpng_pkg::REG_ENERGY_FLOOR]) e = 32'(regs[bpng_pkg::REG_ENERGY_FLOOR]);
    n = noise[b];
    if (n == 0) n = e;
    else n = smooth_step(n, e, (e < n) ? regs[bpng_pkg::REG_NOISE_FALL]
                                       : regs[bpng_pkg::REG_NOISE_RISE]);
    noise[b] = n;
    if (!gate_st[b]) begin
      if ((longint'(e) << 12) > longint'(n) * longint'(regs[bpng_pkg::REG_GATE_OPEN]))
        gate_st[b] = 1;
    end else if ((longint'(e) << 12) <
                 longint'(n) * longint'(regs[bpng_pkg::REG_GATE_CLOSE])) begin
      gate_st[b] = 0;
    end
    if (!gate_st[b]) e = n;
    s = smooth_step(smooth[b], e, regs[bpng_pkg::REG_SMOOTH]);
    smooth[b] = s;
    if (e == 0) begin
      r = 0;
    end else begin
      x = longint'(s) + 105;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      lx = log2_energy(32'(x));
      t = log2_energy(e) - ((longint'(53740) * lx) >>> 16);
      r = pow2_q16(t);
    end
    sq = sqrt_floor((r + 183501) << 16);
    sq0 = sqrt_floor(64'd183501 << 16);
    p = ((sq > sq0) ? sq - sq0 : 0) >> 4;
    pcen = (p > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(p);
    trans = (pcen > prev_pcen[b]) ? longint'(pcen - prev_pcen[b]) : 0;
    lvl = (longint'(pcen) * longint'(regs[bpng_pkg::REG_LEVEL_GAIN])
           + trans * longint'(regs[bpng_pkg::REG_ONSET_GAIN])) >> 12;
    if (lvl > 64000) lvl = 64000;
    prev_pcen[b] = pcen;
    res.band = b;
    res.level = 16'(lvl);
    res.gate = gate_st[b];
    pending_q.push_back(res);
  endfunction

  function void check_word(logic [4:0] b, logic [15:0] level, logic gate);
    band_result_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected word band=%0d level=%0d gate=%0b", $time, b, level, gate);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (b !== exp_r.band) begin
      $display("%0t: band_out expected %0d actual %0d", $time, exp_r.band, b);
      errors++;
    end
    if (level !== exp_r.level) begin
      $display("%0t: level (band %0d) expected %0d actual %0d", $time, exp_r.band,
               exp_r.level, level);
      errors++;
    end
    if (gate !== exp_r.gate) begin
      $display("%0t: gate_open (band %0d) expected %0b actual %0b", $time, exp_r.band,
               exp_r.gate, gate);
      errors++;
    end
  endfunction
endclass

module band_pcen_noise_gate_core_tb;
  import bpng_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  band_i = '0;
  logic [31:0] energy_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  band_out_o;
  logic [15:0] level_o;
  logic        gate_open_o;

  gate_scoreboard sb = new();
  bit   quiet = 0;
  bit   hold_req = 0;
  int   cycles = 0;

  band_pcen_noise_gate_core dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(band_out_o, level_o, gate_open_o);

  // output stall: random bursts, plus one long hold when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_word(logic [4:0] b, logic [31:0] e);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    in_valid_i = 1'b1;
    band_i = b;
    energy_i = e;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(b, e);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.regs[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_phase(int n_words);
    logic [4:0]  b;
    logic [31:0] e;
    for (int i = 0; i < n_words; i++) begin
      // mostly a few hot bands with loud/quiet swings to work the gate
      b = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      case ($urandom_range(0, 9))
        0:       e = '0;
        1:       e = 32'hFFFF_FFFF;
        2, 3, 4: e = 32'($urandom_range(0, 400));
        default: e = $urandom >> $urandom_range(0, 31);
      endcase
      send_word(b, e);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, gate open/close, decay to zero
    send_word(5'd0, 32'd0);
    send_word(5'd0, 32'hFFFF_FFFF);
    send_word(5'd31, 32'hFFFF_FFFF);
    send_word(5'd31, 32'd0);
    send_word(5'd31, 32'd0);
    for (int i = 0; i < 3; i++) send_word(5'd5, 32'd200);
    for (int i = 0; i < 3; i++) send_word(5'd5, 32'd5000000);
    for (int i = 0; i < 3; i++) send_word(5'd5, 32'd100);
    drain();
    // zero floor with full fall rate: noise hits zero and reseeds
    write_reg(REG_ENERGY_FLOOR, 16'd0);
    write_reg(REG_NOISE_FALL, 16'hFFFF);
    send_word(5'd7, 32'd1000);
    send_word(5'd7, 32'd0);
    send_word(5'd7, 32'd0);
    send_word(5'd7, 32'd1);
    send_word(5'd7, 32'd0);
    send_word(5'd7, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        case (ph)
          0:       write_reg(reg_idx_e'(k), REG_RESET[k]);
          1:       write_reg(reg_idx_e'(k), 16'h0000);
          2:       write_reg(reg_idx_e'(k), 16'hFFFF);
          default: write_reg(reg_idx_e'(k), 16'($urandom));
        endcase
      end
      // sensible gate ratios most of the time
      if (ph >= 3 && ph != 4) begin
        write_reg(REG_GATE_OPEN, 16'($urandom_range(4096, 8192)));
        write_reg(REG_GATE_CLOSE, 16'($urandom_range(2048, 4096)));
      end
      if (ph == 2) hold_req = 1;
      if (ph == 6) quiet = 1;
      random_phase(150);
      drain();
    end

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire
